// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define PRST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked check, also through reset
`define PRST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/prst_pkg.sv -----
package prst_pkg;

  localparam int CAPACITY_DEF       = 16;
  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int PRIORITY_WIDTH_DEF = 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_POP_EMPTY,
    ST_PUSH_FULL
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_HEAD,
    S_POP
  } state_t;

endpackage

// ----- rtl/priority_stack.sv -----
// Channel   Handshake            Fields
// request   start, busy          opcode, item_value, item_priority
// result    done (1-cycle pulse) head_value, head_priority, entry_count, is_empty, status
//
// A request is taken when start is high and busy is low; its result pulses done later.
// Entries sit in a single RAM, head at address 0; one compare-and-move step per cycle.
// Push: finishes from idle when full or empty; else shifts entries down, tail first.
// Pop: finishes from idle for up to one entry, else shifts entries up toward the head.
// Synchronous reset empties the stack at once; RAM contents are left as they are.
// The result pulse cannot be held off; a new request may be taken in the done cycle.
`include "assert_macros.svh"

module priority_stack
  import prst_pkg::*;
#(
  parameter int CAPACITY       = CAPACITY_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic [VALUE_WIDTH-1:0]             item_value,
  input  logic [PRIORITY_WIDTH-1:0]          item_priority,
  output logic                               done,
  output logic [VALUE_WIDTH-1:0]             head_value,
  output logic [PRIORITY_WIDTH-1:0]          head_priority,
  output logic [$clog2(CAPACITY+1)-1:0]      entry_count,
  output logic                               is_empty,
  output logic [1:0]                         status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = VALUE_WIDTH + PRIORITY_WIDTH;

  state_t                    state, state_next;
  logic [AW-1:0]             idx, idx_next;
  logic [CW-1:0]             count, count_next;
  logic [VALUE_WIDTH-1:0]    new_val, new_val_next;
  logic [PRIORITY_WIDTH-1:0] new_pri, new_pri_next;
  logic [VALUE_WIDTH-1:0]    top_val, top_val_next;
  logic [PRIORITY_WIDTH-1:0] top_pri, top_pri_next;

  logic                      finish;
  status_t                   fin_status;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic [EW-1:0]             wdata, rdata;
  logic [VALUE_WIDTH-1:0]    rd_val;
  logic [PRIORITY_WIDTH-1:0] rd_pri;

  prst_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_val = rdata[EW-1:PRIORITY_WIDTH];
  assign rd_pri = rdata[PRIORITY_WIDTH-1:0];
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    new_val <= new_val_next;
    new_pri <= new_pri_next;
    top_val <= top_val_next;
    top_pri <= top_pri_next;
    if (finish) begin
      status      <= fin_status;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      head_value  <= (count_next == '0) ? '0 : top_val_next;
      head_priority <= (count_next == '0) ? '0 : top_pri_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    count_next   = count;
    new_val_next = new_val;
    new_pri_next = new_pri;
    top_val_next = top_val;
    top_pri_next = top_pri;
    finish       = 1'b0;
    fin_status   = ST_OK;
    we           = 1'b0;
    waddr        = '0;
    wdata        = '0;
    re           = 1'b0;
    raddr        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_PUSH) begin
            new_val_next = item_value;
            new_pri_next = item_priority;
            if (count == CW'(CAPACITY)) begin
              finish     = 1'b1;
              fin_status = ST_PUSH_FULL;
            end else if (count == '0) begin
              we           = 1'b1;
              wdata        = {item_value, item_priority};
              top_val_next = item_value;
              top_pri_next = item_priority;
              count_next   = CW'(1);
              finish       = 1'b1;
            end else begin
              re         = 1'b1;
              raddr      = AW'(count - 1'b1);
              idx_next   = AW'(count - 1'b1);
              state_next = S_PUSH;
            end
          end else begin
            if (count == '0) begin
              finish     = 1'b1;
              fin_status = ST_POP_EMPTY;
            end else if (count == CW'(1)) begin
              count_next = '0;
              finish     = 1'b1;
            end else begin
              re         = 1'b1;
              raddr      = AW'(1);
              idx_next   = AW'(1);
              state_next = S_POP;
            end
          end
        end
      end
      S_PUSH: begin
        we    = 1'b1;
        waddr = idx + 1'b1;
        if (rd_pri > new_pri) begin
          wdata      = {new_val, new_pri};
          count_next = count + 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          wdata = rdata;
          if (idx == '0) begin
            state_next = S_PUSH_HEAD;
          end else begin
            re       = 1'b1;
            raddr    = idx - 1'b1;
            idx_next = idx - 1'b1;
          end
        end
      end
      S_PUSH_HEAD: begin
        we           = 1'b1;
        wdata        = {new_val, new_pri};
        top_val_next = new_val;
        top_pri_next = new_pri;
        count_next   = count + 1'b1;
        finish       = 1'b1;
        state_next   = S_IDLE;
      end
      S_POP: begin
        we    = 1'b1;
        waddr = idx - 1'b1;
        wdata = rdata;
        if (idx == AW'(1)) begin
          top_val_next = rd_val;
          top_pri_next = rd_pri;
        end
        if (CW'(idx) == count - 1'b1) begin
          count_next = count - 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          re       = 1'b1;
          raddr    = idx + 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PRST_ASSERT_ALWAYS(a_done_when_idle, done |-> !busy, "result pulsed while busy")
  `PRST_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done),
               "accepted request neither in progress nor finished")
  `PRST_ASSERT(a_count_bound, done |-> (entry_count <= CW'(CAPACITY)),
               "entry count beyond capacity")
  `PRST_ASSERT(a_full_status, (done && status == ST_PUSH_FULL) |-> (entry_count == CW'(CAPACITY)),
               "push-full status with spare room")

endmodule

// ----- rtl/prst_ram.sv -----
module prst_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
